FILE: rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int RAW_W        = 10;
  localparam int BYTE_W       = 8;
  localparam int FRAME_BYTES  = 25;
  localparam int NUM_CHANNELS = 18;
  localparam int STD_CHANNELS = 16;
  localparam int CHAN_W       = 11;
  localparam int NUM_W        = 5;
  localparam int PULSE_W      = 12;
  localparam int CNT_W        = 32;
  localparam int POS_W        = $clog2(FRAME_BYTES + 1);

  // Bits of the standard channels: bytes 1 through 22 of the frame.
  localparam int CHAN_BITS  = STD_CHANNELS * CHAN_W;
  localparam int CHAN_BYTES = CHAN_BITS / BYTE_W;

  localparam int FLAGS_INDEX   = 23;
  localparam int FLAG_DIG17    = 0;
  localparam int FLAG_DIG18    = 1;
  localparam int FLAG_LOST     = 2;
  localparam int FLAG_FAILSAFE = 3;

  localparam logic [BYTE_W-1:0]  START_BYTE   = 8'h0F;
  localparam logic [CHAN_W-1:0]  DIG_LOW      = 11'd173;
  localparam logic [CHAN_W-1:0]  DIG_HIGH     = 11'd1812;
  localparam logic [PULSE_W-1:0] PULSE_OFFSET = 12'd880;

  // One judged frame, handed from the front part to the back part.
  typedef struct packed {
    logic                 rejected;
    logic                 dig17;
    logic                 dig18;
    logic                 lost;
    logic                 failsafe;
    logic [CHAN_BITS-1:0] chan_bits;
    logic [CNT_W-1:0]     good_count;
    logic [CNT_W-1:0]     lost_count;
    logic [CNT_W-1:0]     error_count;
  } frame_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

FILE: rtl/sfd_word_if.sv
interface sfd_word_if import sfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_word;
  logic             end_of_frame;

  modport source (output valid, output raw_word, output end_of_frame, input ready);
  modport sink (input valid, input raw_word, input end_of_frame, output ready);
endinterface

FILE: rtl/sfd_result_if.sv
interface sfd_result_if import sfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NUM_W-1:0]   channel_number;
  logic [CHAN_W-1:0]  channel_value;
  logic [PULSE_W-1:0] channel_pulse;
  logic               frame_rejected;
  logic               signal_lost;
  logic               failsafe_active;
  logic [CNT_W-1:0]   good_count;
  logic [CNT_W-1:0]   lost_count;
  logic [CNT_W-1:0]   error_count;
  logic               last_result;

  modport source (
    output valid, output channel_number, output channel_value, output channel_pulse,
    output frame_rejected, output signal_lost, output failsafe_active,
    output good_count, output lost_count, output error_count, output last_result,
    input ready
  );
  modport sink (
    input valid, input channel_number, input channel_value, input channel_pulse,
    input frame_rejected, input signal_lost, input failsafe_active,
    input good_count, input lost_count, input error_count, input last_result,
    output ready
  );
endinterface

FILE: rtl/sfd_front.sv
module sfd_front import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sfd_word_if.sink   words,
  input  logic       q_full,
  output logic       push,
  output frame_t     push_data
);

  logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
  logic [BYTE_W-1:0] byte_view   [FRAME_BYTES];
  logic [POS_W-1:0]  word_position;
  logic              parity_failed;
  logic [CNT_W-1:0]  good_frames;
  logic [CNT_W-1:0]  lost_frames;
  logic [CNT_W-1:0]  error_frames;

  logic [RAW_W-1:0]  word;
  logic [BYTE_W-1:0] data;
  logic              parity_bad;
  logic              accept;
  logic              rejected;
  logic [BYTE_W-1:0] flags;
  logic              bump_good;
  logic              bump_lost;

  assign words.ready = !q_full;
  assign accept      = words.valid && words.ready;

  assign word       = ~words.raw_word;
  assign data       = word[BYTE_W:1];
  assign parity_bad = (^data) != word[RAW_W-1];

  // The frame as it stands once the current word has been written.
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      byte_view[i] = (word_position == POS_W'(i)) ? data : frame_bytes[i];
    end
  end

  assign flags     = byte_view[FLAGS_INDEX];
  assign rejected  = parity_failed || parity_bad || (byte_view[0] != START_BYTE);
  assign bump_lost = !rejected && flags[FLAG_LOST];
  assign bump_good = !rejected && !flags[FLAG_LOST] && !flags[FLAG_FAILSAFE];

  assign push = accept && words.end_of_frame;

  always_comb begin
    push_data             = '0;
    push_data.rejected    = rejected;
    push_data.dig17       = flags[FLAG_DIG17];
    push_data.dig18       = flags[FLAG_DIG18];
    push_data.lost        = flags[FLAG_LOST];
    push_data.failsafe    = flags[FLAG_FAILSAFE];
    for (int j = 0; j < CHAN_BYTES; j++) begin
      push_data.chan_bits[j*BYTE_W +: BYTE_W] = byte_view[j+1];
    end
    push_data.good_count  = good_frames + CNT_W'(bump_good);
    push_data.lost_count  = lost_frames + CNT_W'(bump_lost);
    push_data.error_count = error_frames + CNT_W'(rejected);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_bytes[i] <= '0;
      end
      word_position <= '0;
      parity_failed <= 1'b0;
      good_frames   <= '0;
      lost_frames   <= '0;
      error_frames  <= '0;
    end else if (accept) begin
      if (word_position < POS_W'(FRAME_BYTES)) begin
        frame_bytes[word_position] <= data;
      end
      if (words.end_of_frame) begin
        word_position <= '0;
        parity_failed <= 1'b0;
        good_frames   <= push_data.good_count;
        lost_frames   <= push_data.lost_count;
        error_frames  <= push_data.error_count;
      end else begin
        if (word_position < POS_W'(FRAME_BYTES)) begin
          word_position <= POS_W'(word_position + 1'b1);
        end
        parity_failed <= parity_failed || parity_bad;
      end
    end
  end

endmodule

FILE: rtl/sfd_queue.sv
module sfd_queue import sfd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output frame_t pop_data,
  output logic   not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_Q = $clog2(DEPTH + 1);

  frame_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_Q-1:0]   fill;

  assign full      = fill == CNT_Q'(DEPTH);
  assign not_empty = fill != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= CNT_Q'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= CNT_Q'(fill - 1'b1);
      end
    end
  end

endmodule

FILE: rtl/sfd_back.sv
module sfd_back import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  frame_t      q_data,
  output logic        pop,
  sfd_result_if.source results
);

  back_state_t        state;
  back_state_t        state_next;
  frame_t             cur;
  logic [NUM_W-1:0]   chan_idx;
  logic               advance;
  logic               emit;
  logic               last_step;
  logic               dig_bit;
  logic [CHAN_W-1:0]  value;
  logic [CHAN_W+2:0]  times5;
  logic [PULSE_W-1:0] pulse;

  assign advance   = !results.valid || results.ready;
  assign last_step = cur.rejected || (chan_idx == NUM_W'(NUM_CHANNELS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) state_next = BK_RUN;
      end
      BK_RUN: begin
        if (advance && last_step) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == BK_IDLE) && q_valid;
    emit = (state == BK_RUN) && advance;
  end

  // Standard channels come off the bottom of the shifted field; the two
  // digital channels follow from their flag bits.
  assign dig_bit = (chan_idx == NUM_W'(NUM_CHANNELS - 1)) ? cur.dig18 : cur.dig17;
  assign value   = (chan_idx < NUM_W'(STD_CHANNELS)) ? cur.chan_bits[CHAN_W-1:0]
                 : (dig_bit ? DIG_HIGH : DIG_LOW);
  assign times5  = {3'b000, value} + {1'b0, value, 2'b00};
  assign pulse   = PULSE_W'(times5[CHAN_W+2:3]) + PULSE_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= q_data;
      chan_idx <= '0;
    end else if (emit && !last_step) begin
      cur.chan_bits <= cur.chan_bits >> CHAN_W;
      chan_idx      <= NUM_W'(chan_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.good_count  <= cur.good_count;
      results.lost_count  <= cur.lost_count;
      results.error_count <= cur.error_count;
      results.last_result <= last_step;
      if (cur.rejected) begin
        results.channel_number  <= '0;
        results.channel_value   <= '0;
        results.channel_pulse   <= '0;
        results.frame_rejected  <= 1'b1;
        results.signal_lost     <= 1'b0;
        results.failsafe_active <= 1'b0;
      end else begin
        results.channel_number  <= NUM_W'(chan_idx + 1'b1);
        results.channel_value   <= value;
        results.channel_pulse   <= pulse;
        results.frame_rejected  <= 1'b0;
        results.signal_lost     <= cur.lost;
        results.failsafe_active <= cur.failsafe;
      end
    end
  end

endmodule

FILE: rtl/sbus_frame_decoder_top.sv
// Decoder for SBUS receiver frames. Each item on the words channel is one
// sampled serial word as it comes off the line, still inverted, and the item
// with end_of_frame set closes the frame. The front part takes one word per
// cycle, checks its even parity, stores its data byte and, on the closing word,
// judges the frame and updates the good, lost and error counters. A judged
// frame goes into a small queue of QUEUE_DEPTH entries. The back part takes one
// frame out of the queue while idle and then gives one result per cycle while
// the results channel is ready: 18 results for an accepted frame (16 standard
// channels, then the two digital channels) or a single result for a rejected
// frame. The back part takes no new frame out of the queue until it has given
// the last result of the current one. Words are accepted at one per cycle
// whenever the queue has room; the words channel stalls only when the queue is
// full, which happens only if closing words arrive faster than the back part
// drains frames. A closing word's frame passes through the queue, the back
// part's frame register and the result registers before its first result
// appears. Bytes that a short frame does not write keep their values from
// earlier frames, and words past the 25th are checked for parity but not stored.
module sbus_frame_decoder_top import sfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  sfd_word_if.sink     words,
  sfd_result_if.source results
);

  logic   q_full;
  logic   q_push;
  frame_t q_push_data;
  logic   q_pop;
  frame_t q_pop_data;
  logic   q_valid;

  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .words     (words),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  sfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .pop     (q_pop),
    .results (results)
  );

endmodule

FILE: rtl/sfd_checker.sv
module sfd_checker import sfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [NUM_W-1:0]   channel_number,
  input logic [CHAN_W-1:0]  channel_value,
  input logic               frame_rejected,
  input logic [CNT_W-1:0]   good_count,
  input logic [CNT_W-1:0]   lost_count,
  input logic [CNT_W-1:0]   error_count,
  input logic               last_result
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(channel_number)
      && $stable(channel_value) && $stable(last_result))
    else $error("stalled result changed");

  // A rejected frame gives exactly one empty result.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_rejected |-> channel_number == '0 && channel_value == '0
      && last_result)
    else $error("bad rejected-frame result");

  // An accepted frame ends exactly on its last channel.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_rejected |-> channel_number != '0
      && (last_result == (channel_number == NUM_W'(NUM_CHANNELS))))
    else $error("frame end misplaced");

  // Counters do not move within a frame.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !last_result |=> $stable(good_count) && $stable(lost_count)
      && $stable(error_count))
    else $error("counters changed inside a frame");

  // Digital channels carry one of their two codes.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_rejected && channel_number > NUM_W'(STD_CHANNELS)
      |-> channel_value == DIG_LOW || channel_value == DIG_HIGH)
    else $error("bad digital channel value");

endmodule

bind sbus_frame_decoder_top sfd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .channel_number (results.channel_number),
  .channel_value  (results.channel_value),
  .frame_rejected (results.frame_rejected),
  .good_count     (results.good_count),
  .lost_count     (results.lost_count),
  .error_count    (results.error_count),
  .last_result    (results.last_result)
);
